@@ rtl/core/scfe_pkg.sv @@
// Shared types, constants and the CRC-8 byte update for the serial command frame encoder.
`default_nettype none

package scfe_pkg;

    // Protocol version codes of the configuration register
    localparam logic [1:0] PVER_V1   = 2'd0;
    localparam logic [1:0] PVER_NEST = 2'd1;
    localparam logic [1:0] PVER_V2   = 2'd2;

    // Input opcodes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    localparam logic [15:0] JUMBO_LIMIT  = 16'd255;
    localparam logic [15:0] MAX_LEN      = 16'd65529;
    localparam logic [15:0] NEST_OVERHEAD = 16'd6;
    localparam logic [7:0]  NEST_CMD     = 8'd255;
    localparam logic [7:0]  CRC_POLY     = 8'hD5;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_M      = 8'h4D;
    localparam logic [7:0] CHAR_X      = 8'h58;
    localparam logic [7:0] CHAR_GT     = 8'h3E;
    localparam logic [7:0] CHAR_BANG   = 8'h21;

    // One state per emitted byte kind
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOLLAR,
        ST_MAGIC,
        ST_DIR,
        ST_V1_SIZE,
        ST_V1_CMD,
        ST_V1_JLO,
        ST_V1_JHI,
        ST_V2_FLAGS,
        ST_V2_CMD_LO,
        ST_V2_CMD_HI,
        ST_V2_LEN_LO,
        ST_V2_LEN_HI,
        ST_PAYLOAD,
        ST_CRC,
        ST_XOR
    } t_step;

    typedef struct packed {
        logic       clear;
        logic       add_xor;
        logic       add_crc;
        logic [7:0] data;
    } t_sum_ctl;

    // CRC-8 DVB-S2, MSB first, test bit 7 then shift
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/scfe_if.sv @@
// Channel interfaces: input items, configuration writes and frame bytes.
`default_nettype none

interface scfe_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] command;
    logic [15:0] payload_length;
    logic        error_reply;
    logic [7:0]  payload_byte;

    modport source(output valid, output opcode, output command, output payload_length,
                   output error_reply, output payload_byte, input ready);
    modport sink(input valid, input opcode, input command, input payload_length,
                 input error_reply, input payload_byte, output ready);
endinterface

interface scfe_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] protocol_version;

    modport source(output valid, output protocol_version, input ready);
    modport sink(input valid, input protocol_version, output ready);
endinterface

interface scfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source(output valid, output out_byte, output frame_end, input ready);
    modport sink(input valid, input out_byte, input frame_end, output ready);
endinterface

`default_nettype wire

@@ rtl/core/serial_command_frame_encoder_unit.sv @@
// Top level of the serial command frame encoder: item register, byte sequencer, output register.
//
// Channels: i_item takes items (a start item with command, length and error flag, or one
// payload byte), o_frame delivers the encoded frame one byte at a time with frame_end on
// the final checksum byte, i_cfg writes protocol_version (0 v1, 1 v2 inside v1, 2 v2).
// i_cfg is always ready; write it only while no frame bytes are outstanding.
// An accepted item is held in a job register and a sequencer emits its bytes into the
// output register, one byte per cycle while o_frame does not stall. An item's first byte
// reaches o_frame through the state and output registers. A start item emits the header,
// plus checksums for an empty payload; a payload item emits its byte, plus checksums on a
// frame's last byte. The next item is accepted in the cycle the current job emits its last
// byte, so payload bytes stream at one per cycle; payload outside a frame is dropped.
// Reset clears the register to v1, closes any open frame, clears checksums and empties
// the output register. When o_frame stalls, the output register holds its byte, the
// sequencer holds, and i_item.ready drops once the job register is occupied.
`default_nettype none

module serial_command_frame_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scfe_in_if.sink     i_item,
    scfe_cfg_if.sink    i_cfg,
    scfe_out_if.source  o_frame
);

    scfe_pkg::t_step    r_state;
    scfe_pkg::t_step    n_state;
    scfe_pkg::t_step    n_succ;
    scfe_pkg::t_step    first_step;
    scfe_pkg::t_step    chk_first;
    scfe_pkg::t_sum_ctl sum_ctl;

    logic [1:0]  r_pver;
    logic [15:0] r_cmd;
    logic [15:0] r_len;
    logic        r_err;
    logic [7:0]  r_pb;
    logic [15:0] r_bytes_left;
    logic [15:0] n_bytes_left;
    logic        r_in_frame;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_end;

    logic [7:0]  xor_sum;
    logic [7:0]  crc_sum;

    logic        mode_v2;
    logic        mode_nest;
    logic [15:0] v1_size_val;
    logic        jumbo;

    logic        emit;
    logic [7:0]  step_byte;
    logic        to_xor;
    logic        to_crc;
    logic        step_end;
    logic        step_last;
    logic        out_free;
    logic        fire;
    logic        advance;
    logic        item_ready;
    logic        accept;

    // Register value 3 behaves as v1
    assign mode_v2   = (r_pver == scfe_pkg::PVER_V2);
    assign mode_nest = (r_pver == scfe_pkg::PVER_NEST);

    assign v1_size_val  = mode_nest ? (r_len + scfe_pkg::NEST_OVERHEAD) : r_len;
    assign jumbo        = (v1_size_val >= scfe_pkg::JUMBO_LIMIT);
    assign chk_first    = (mode_nest || mode_v2) ? scfe_pkg::ST_CRC : scfe_pkg::ST_XOR;
    assign n_bytes_left = r_bytes_left - {15'd0, (r_bytes_left != 16'd0)};
    assign first_step   = (i_item.opcode == scfe_pkg::OP_START) ? scfe_pkg::ST_DOLLAR
                                                                : scfe_pkg::ST_PAYLOAD;

    // Byte, checksum coverage and job end for the current step
    always_comb begin
        emit      = 1'b1;
        step_byte = 8'd0;
        to_xor    = 1'b0;
        to_crc    = 1'b0;
        step_end  = 1'b0;
        step_last = 1'b0;
        unique case (r_state)
            scfe_pkg::ST_IDLE: begin
                emit = 1'b0;
            end
            scfe_pkg::ST_DOLLAR: begin
                step_byte = scfe_pkg::CHAR_DOLLAR;
            end
            scfe_pkg::ST_MAGIC: begin
                step_byte = mode_v2 ? scfe_pkg::CHAR_X : scfe_pkg::CHAR_M;
            end
            scfe_pkg::ST_DIR: begin
                step_byte = r_err ? scfe_pkg::CHAR_BANG : scfe_pkg::CHAR_GT;
            end
            scfe_pkg::ST_V1_SIZE: begin
                step_byte = jumbo ? scfe_pkg::JUMBO_LIMIT[7:0] : v1_size_val[7:0];
                to_xor    = 1'b1;
            end
            scfe_pkg::ST_V1_CMD: begin
                step_byte = mode_nest ? scfe_pkg::NEST_CMD : r_cmd[7:0];
                to_xor    = 1'b1;
                step_last = !mode_nest && !jumbo && (r_len != 16'd0);
            end
            scfe_pkg::ST_V1_JLO: begin
                step_byte = v1_size_val[7:0];
                to_xor    = 1'b1;
            end
            scfe_pkg::ST_V1_JHI: begin
                step_byte = v1_size_val[15:8];
                to_xor    = 1'b1;
                step_last = !mode_nest && (r_len != 16'd0);
            end
            scfe_pkg::ST_V2_FLAGS: begin
                step_byte = 8'd0;
                to_xor    = mode_nest;
                to_crc    = 1'b1;
            end
            scfe_pkg::ST_V2_CMD_LO: begin
                step_byte = r_cmd[7:0];
                to_xor    = mode_nest;
                to_crc    = 1'b1;
            end
            scfe_pkg::ST_V2_CMD_HI: begin
                step_byte = r_cmd[15:8];
                to_xor    = mode_nest;
                to_crc    = 1'b1;
            end
            scfe_pkg::ST_V2_LEN_LO: begin
                step_byte = r_len[7:0];
                to_xor    = mode_nest;
                to_crc    = 1'b1;
            end
            scfe_pkg::ST_V2_LEN_HI: begin
                step_byte = r_len[15:8];
                to_xor    = mode_nest;
                to_crc    = 1'b1;
                step_last = (r_len != 16'd0);
            end
            scfe_pkg::ST_PAYLOAD: begin
                // Outside a frame the item is dropped without output
                emit      = r_in_frame;
                step_byte = r_pb;
                to_xor    = !mode_v2;
                to_crc    = mode_v2 || mode_nest;
                step_last = !r_in_frame || (n_bytes_left != 16'd0);
            end
            scfe_pkg::ST_CRC: begin
                step_byte = crc_sum;
                to_xor    = mode_nest;
                step_end  = !mode_nest;
                step_last = !mode_nest;
            end
            scfe_pkg::ST_XOR: begin
                step_byte = xor_sum;
                step_end  = 1'b1;
                step_last = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Successor step within the current job
    always_comb begin
        n_succ = scfe_pkg::ST_IDLE;
        unique case (r_state)
            scfe_pkg::ST_DOLLAR:    n_succ = scfe_pkg::ST_MAGIC;
            scfe_pkg::ST_MAGIC:     n_succ = scfe_pkg::ST_DIR;
            scfe_pkg::ST_DIR:       n_succ = mode_v2 ? scfe_pkg::ST_V2_FLAGS
                                                     : scfe_pkg::ST_V1_SIZE;
            scfe_pkg::ST_V1_SIZE:   n_succ = scfe_pkg::ST_V1_CMD;
            scfe_pkg::ST_V1_CMD: begin
                if (jumbo) begin
                    n_succ = scfe_pkg::ST_V1_JLO;
                end else if (mode_nest) begin
                    n_succ = scfe_pkg::ST_V2_FLAGS;
                end else begin
                    n_succ = chk_first;
                end
            end
            scfe_pkg::ST_V1_JLO:    n_succ = scfe_pkg::ST_V1_JHI;
            scfe_pkg::ST_V1_JHI:    n_succ = mode_nest ? scfe_pkg::ST_V2_FLAGS : chk_first;
            scfe_pkg::ST_V2_FLAGS:  n_succ = scfe_pkg::ST_V2_CMD_LO;
            scfe_pkg::ST_V2_CMD_LO: n_succ = scfe_pkg::ST_V2_CMD_HI;
            scfe_pkg::ST_V2_CMD_HI: n_succ = scfe_pkg::ST_V2_LEN_LO;
            scfe_pkg::ST_V2_LEN_LO: n_succ = scfe_pkg::ST_V2_LEN_HI;
            scfe_pkg::ST_V2_LEN_HI: n_succ = chk_first;
            scfe_pkg::ST_PAYLOAD:   n_succ = chk_first;
            scfe_pkg::ST_CRC:       n_succ = scfe_pkg::ST_XOR;
            scfe_pkg::ST_XOR:       n_succ = scfe_pkg::ST_IDLE;
            scfe_pkg::ST_IDLE:      n_succ = scfe_pkg::ST_IDLE;
            default:                n_succ = scfe_pkg::ST_IDLE;
        endcase
    end

    assign out_free   = !r_out_valid || o_frame.ready;
    assign fire       = emit && out_free;
    assign advance    = fire || ((r_state == scfe_pkg::ST_PAYLOAD) && !r_in_frame);
    assign item_ready = (r_state == scfe_pkg::ST_IDLE) || (advance && step_last);
    assign accept     = i_item.valid && item_ready;

    always_comb begin
        n_state = r_state;
        if (advance && !step_last) begin
            n_state = n_succ;
        end else if (item_ready) begin
            n_state = accept ? first_step : scfe_pkg::ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scfe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Job register; length saturates at the protocol maximum
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_item.command;
            r_len <= (i_item.payload_length > scfe_pkg::MAX_LEN) ? scfe_pkg::MAX_LEN
                                                                 : i_item.payload_length;
            r_err <= i_item.error_reply;
            r_pb  <= i_item.payload_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pver <= scfe_pkg::PVER_V1;
        end else if (i_cfg.valid) begin
            r_pver <= i_cfg.protocol_version;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 16'd0;
            r_in_frame   <= 1'b0;
        end else begin
            if (fire && (r_state == scfe_pkg::ST_DOLLAR)) begin
                r_bytes_left <= r_len;
                r_in_frame   <= 1'b1;
            end else if (fire && (r_state == scfe_pkg::ST_PAYLOAD)) begin
                r_bytes_left <= n_bytes_left;
            end
            if (fire && step_end) begin
                r_in_frame <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_byte <= step_byte;
            r_out_end  <= step_end;
        end
    end

    always_comb begin
        sum_ctl.clear   = fire && (r_state == scfe_pkg::ST_DOLLAR);
        sum_ctl.add_xor = fire && to_xor;
        sum_ctl.add_crc = fire && to_crc;
        sum_ctl.data    = step_byte;
    end

    scfe_chksum u_chksum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (sum_ctl),
        .o_xor_sum (xor_sum),
        .o_crc_sum (crc_sum)
    );

    assign i_item.ready      = item_ready;
    assign i_cfg.ready       = 1'b1;
    assign o_frame.valid     = r_out_valid;
    assign o_frame.out_byte  = r_out_byte;
    assign o_frame.frame_end = r_out_end;

endmodule

`default_nettype wire

@@ rtl/core/scfe_chksum.sv @@
// Running XOR and CRC-8 checksums over the bytes of one frame.
`default_nettype none

module scfe_chksum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scfe_pkg::t_sum_ctl i_ctl,
    output logic [7:0]        o_xor_sum,
    output logic [7:0]        o_crc_sum
);

    logic [7:0] r_xor_sum;
    logic [7:0] r_crc_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor_sum <= 8'd0;
            r_crc_sum <= 8'd0;
        end else if (i_ctl.clear) begin
            r_xor_sum <= 8'd0;
            r_crc_sum <= 8'd0;
        end else begin
            if (i_ctl.add_xor) begin
                r_xor_sum <= r_xor_sum ^ i_ctl.data;
            end
            if (i_ctl.add_crc) begin
                r_crc_sum <= scfe_pkg::crc8_byte(r_crc_sum, i_ctl.data);
            end
        end
    end

    assign o_xor_sum = r_xor_sum;
    assign o_crc_sum = r_crc_sum;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the serial command frame encoder: frame bytes against a predictor.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] PVER_SPARE   = 2'd3;
    localparam int         CLK_HALF     = 10;
    localparam int         RESET_CYCLES = 10;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         BURST_MAX    = 12;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_wire_byte;

    logic i_clk;
    logic i_rst_n;

    scfe_in_if  item_if ();
    scfe_cfg_if cfg_if ();
    scfe_out_if frame_if ();

    serial_command_frame_encoder_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .i_cfg   (cfg_if),
        .o_frame (frame_if)
    );

    // Predicted wire bytes, oldest first
    t_wire_byte frame_bytes_q[$];

    // Predictor copy of the block state
    logic [1:0]  pver_model;
    logic [7:0]  xor_acc;
    logic [7:0]  crc_acc;
    logic [15:0] remaining;
    logic        frame_open;
    int          burst_n;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_token;
    int fail_count;
    int cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [7:0] dvb_crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] acc;
        acc = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (acc[7]) begin
                acc = (acc << 1) ^ scfe_pkg::CRC_POLY;
            end else begin
                acc = acc << 1;
            end
        end
        return acc;
    endfunction

    function automatic void put_byte(input logic [7:0] b, input logic to_xor,
                                     input logic to_crc, input logic last);
        t_wire_byte wb;
        if (burst_n >= BURST_MAX) return;
        if (to_xor) xor_acc = xor_acc ^ b;
        if (to_crc) crc_acc = dvb_crc_update(crc_acc, b);
        wb.data = b;
        wb.last = last;
        frame_bytes_q = {frame_bytes_q, wb};
        burst_n++;
    endfunction

    function automatic void close_frame(input logic [1:0] mode);
        if (mode == scfe_pkg::PVER_V1) begin
            put_byte(xor_acc, 1'b0, 1'b0, 1'b1);
        end else if (mode == scfe_pkg::PVER_NEST) begin
            put_byte(crc_acc, 1'b1, 1'b0, 1'b0);
            put_byte(xor_acc, 1'b0, 1'b0, 1'b1);
        end else begin
            put_byte(crc_acc, 1'b0, 1'b0, 1'b1);
        end
        frame_open = 1'b0;
    endfunction

    // Work out the wire bytes that one accepted item causes
    function automatic void encode_item(input logic op, input logic [15:0] cmd,
                                        input logic [15:0] len_in, input logic err,
                                        input logic [7:0] pb);
        logic [1:0]  mode;
        logic [15:0] len;
        logic [15:0] nest_size;
        logic        nested;
        mode = (pver_model == PVER_SPARE) ? scfe_pkg::PVER_V1 : pver_model;
        len = (len_in > scfe_pkg::MAX_LEN) ? scfe_pkg::MAX_LEN : len_in;
        burst_n = 0;
        if (op == scfe_pkg::OP_START) begin
            xor_acc = 8'h00;
            crc_acc = 8'h00;
            put_byte(scfe_pkg::CHAR_DOLLAR, 1'b0, 1'b0, 1'b0);
            put_byte((mode == scfe_pkg::PVER_V2) ? scfe_pkg::CHAR_X : scfe_pkg::CHAR_M,
                     1'b0, 1'b0, 1'b0);
            put_byte(err ? scfe_pkg::CHAR_BANG : scfe_pkg::CHAR_GT, 1'b0, 1'b0, 1'b0);
            if (mode == scfe_pkg::PVER_V1) begin
                put_byte((len < scfe_pkg::JUMBO_LIMIT) ? len[7:0]
                                                       : scfe_pkg::JUMBO_LIMIT[7:0],
                         1'b1, 1'b0, 1'b0);
                put_byte(cmd[7:0], 1'b1, 1'b0, 1'b0);
                if (len >= scfe_pkg::JUMBO_LIMIT) begin
                    put_byte(len[7:0], 1'b1, 1'b0, 1'b0);
                    put_byte(len[15:8], 1'b1, 1'b0, 1'b0);
                end
            end else begin
                nested = (mode == scfe_pkg::PVER_NEST);
                if (nested) begin
                    nest_size = len + scfe_pkg::NEST_OVERHEAD;
                    put_byte((nest_size < scfe_pkg::JUMBO_LIMIT) ? nest_size[7:0]
                                                                 : scfe_pkg::JUMBO_LIMIT[7:0],
                             1'b1, 1'b0, 1'b0);
                    put_byte(scfe_pkg::NEST_CMD, 1'b1, 1'b0, 1'b0);
                    if (nest_size >= scfe_pkg::JUMBO_LIMIT) begin
                        put_byte(nest_size[7:0], 1'b1, 1'b0, 1'b0);
                        put_byte(nest_size[15:8], 1'b1, 1'b0, 1'b0);
                    end
                end
                put_byte(8'h00, nested, 1'b1, 1'b0);
                put_byte(cmd[7:0], nested, 1'b1, 1'b0);
                put_byte(cmd[15:8], nested, 1'b1, 1'b0);
                put_byte(len[7:0], nested, 1'b1, 1'b0);
                put_byte(len[15:8], nested, 1'b1, 1'b0);
            end
            remaining = len;
            frame_open = 1'b1;
            if (len == 16'd0) close_frame(mode);
            return;
        end
        // drop payload outside a frame
        if (!frame_open) return;
        put_byte(pb, mode != scfe_pkg::PVER_V2, mode != scfe_pkg::PVER_V1, 1'b0);
        if (remaining > 16'd0) remaining = remaining - 16'd1;
        if (remaining == 16'd0) close_frame(mode);
    endfunction

    // Frame byte checker
    always @(posedge i_clk) begin
        t_wire_byte want;
        if (frame_if.valid === 1'b1 && frame_if.ready === 1'b1) begin
            if (frame_bytes_q.size() == 0) begin
                $error("unexpected frame byte %02h", frame_if.out_byte);
                fail_count++;
            end else begin
                want = frame_bytes_q.pop_front();
                if (frame_if.out_byte !== want.data) begin
                    $error("out_byte mismatch: expected %02h, actual %02h",
                           want.data, frame_if.out_byte);
                    fail_count++;
                end
                if (frame_if.frame_end !== want.last) begin
                    $error("frame_end mismatch: expected %0b, actual %0b",
                           want.last, frame_if.frame_end);
                    fail_count++;
                end
            end
        end
    end

    // Frame receiver with random stalls and an on-demand long hold-off
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        frame_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                frame_if.ready <= 1'b0;
            end else begin
                frame_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Called and returning at a falling edge
    task automatic send_item(input logic op, input logic [15:0] cmd, input logic [15:0] len,
                             input logic err, input logic [7:0] pb);
        while ($urandom_range(99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid          <= 1'b1;
        item_if.opcode         <= op;
        item_if.command        <= cmd;
        item_if.payload_length <= len;
        item_if.error_reply    <= err;
        item_if.payload_byte   <= pb;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        encode_item(op, cmd, len, err, pb);
        @(negedge i_clk);
    endtask

    task automatic send_start(input logic [15:0] cmd, input logic [15:0] len, input logic err);
        send_item(scfe_pkg::OP_START, cmd, len, err, 8'($urandom()));
    endtask

    task automatic send_byte(input logic [7:0] pb);
        send_item(scfe_pkg::OP_PAYLOAD, 16'($urandom()), 16'($urandom()), 1'($urandom()), pb);
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        while (frame_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_version(input logic [1:0] value);
        wait_drained();
        cfg_if.valid            <= 1'b1;
        cfg_if.protocol_version <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        pver_model = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_v1_frames();
        write_version(scfe_pkg::PVER_V1);
        send_start(16'hFFFF, 16'd0, 1'b1);
        send_start(16'h0000, 16'd3, 1'b0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
    endtask

    task automatic test_payload_while_idle();
        send_byte(8'h5A);
    endtask

    task automatic test_long_lengths();
        send_start(16'h1234, 16'd254, 1'b0);
        send_byte(8'h81);
        // abandon the open frames with a new start each time
        send_start(16'h00FF, 16'd255, 1'b1);
        send_start(16'hABCD, 16'hFFFF, 1'b0);
        send_start(16'h0042, 16'd1, 1'b0);
        send_byte(8'h7E);
    endtask

    task automatic test_nested_frames();
        write_version(scfe_pkg::PVER_NEST);
        send_start(16'hFFFF, 16'd0, 1'b0);
        send_start(16'h1001, 16'd2, 1'b1);
        send_byte(8'h3C);
        send_byte(8'hC3);
        send_start(16'h8000, 16'd249, 1'b0);
        send_start(16'h0001, 16'd1, 1'b0);
        send_byte(8'hFF);
    endtask

    task automatic test_v2_frames();
        write_version(scfe_pkg::PVER_V2);
        send_start(16'hFFFF, 16'd0, 1'b1);
        send_start(16'h0000, 16'd1, 1'b0);
        send_byte(8'h80);
    endtask

    task automatic test_version_three();
        write_version(PVER_SPARE);
        send_start(16'h5501, 16'd1, 1'b1);
        send_byte(8'h01);
    endtask

    task automatic test_switch_inside_frame();
        write_version(scfe_pkg::PVER_V1);
        send_start(16'h0066, 16'd2, 1'b0);
        send_byte(8'h11);
        // header bytes are out, the frame is still open
        write_version(scfe_pkg::PVER_V2);
        send_byte(8'h22);
    endtask

    task automatic test_random_frames(input int n_items);
        int          sent;
        int          pick;
        int          n_pay;
        logic [15:0] len;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                if (!frame_open) send_byte(8'($urandom()));
            end else if (pick < 12) begin
                write_version(2'($urandom_range(3)));
            end else begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    len = 16'($urandom_range(6));
                end else if (pick < 90) begin
                    len = 16'($urandom_range(256, 249));
                end else begin
                    len = 16'($urandom());
                end
                send_start(16'($urandom()), len, 1'($urandom()));
                sent++;
                n_pay = (len <= 16'd6) ? int'(len) : $urandom_range(3);
                // cut some frames short so the next start abandons them
                if (n_pay > 0 && $urandom_range(99) < 10) n_pay = $urandom_range(n_pay - 1);
                for (int k = 0; k < n_pay; k++) begin
                    send_byte(8'($urandom()));
                    sent++;
                end
            end
        end
    endtask

    task automatic test_output_backpressure();
        int n_pay;
        n_pay = 20;
        wait_drained();
        hold_token++;
        send_start(16'($urandom()), 16'(n_pay), 1'b0);
        for (int k = 0; k < n_pay; k++) send_byte(8'($urandom()));
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        item_if.valid           = 1'b0;
        item_if.opcode          = scfe_pkg::OP_START;
        item_if.command         = 16'd0;
        item_if.payload_length  = 16'd0;
        item_if.error_reply     = 1'b0;
        item_if.payload_byte    = 8'd0;
        cfg_if.valid            = 1'b0;
        cfg_if.protocol_version = scfe_pkg::PVER_V1;
        pver_model              = scfe_pkg::PVER_V1;
        xor_acc                 = 8'h00;
        crc_acc                 = 8'h00;
        remaining               = 16'd0;
        frame_open              = 1'b0;
        burst_n                 = 0;
        hold_token              = 0;
        fail_count              = 0;
        cycle_count             = 0;
        send_idle_pct           = 6;
        recv_idle_pct           = 70;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_v1_frames();
        test_payload_while_idle();
        test_long_lengths();
        test_nested_frames();
        test_v2_frames();
        test_version_three();
        test_switch_inside_frame();

        test_random_frames(22);
        send_idle_pct = 70;
        recv_idle_pct = 6;
        test_random_frames(22);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(16);
        test_output_backpressure();

        wait_drained();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
